@@ rtl/mpsd_pkg.sv @@
package mpsd_pkg;

	// field widths
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned EVENT_W  = 16;
	localparam int unsigned IN_W     = TIME_W + LEVEL_W;
	localparam int unsigned APB_AW   = 4;
	localparam int unsigned APB_DW   = 32;

	// default lane count
	localparam int unsigned PIN_COUNT_DEF = 16;

	// reset values of the registers
	localparam logic [LEVEL_W-1:0] MASK_RST      = '0;
	localparam logic [COUNT_W-1:0] THRESHOLD_RST = 8'd20;
	localparam logic [TIME_W-1:0]  LOCKOUT_RST   = 16'd200;

	// register indexes (word address)
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_OUTPUT_MASK      = 2'd0;
	localparam reg_idx_t REG_CLOSED_THRESHOLD = 2'd1;
	localparam reg_idx_t REG_LOCKOUT_MS       = 2'd2;

	// configuration handed to the lanes
	typedef struct packed {
		logic [LEVEL_W-1:0] output_mask;
		logic [COUNT_W-1:0] closed_threshold;
		logic [TIME_W-1:0]  lockout_ms;
	} cfg_t;

endpackage

@@ rtl/multi_pin_switch_debouncer_unit.sv @@
// channel  | handshake                | payload
// s_axis   | s_tvalid / s_tready      | s_tdata[15:0] elapsed_ms, [31:16] pin_levels
// m_axis   | m_tvalid / m_tready      | m_tdata[15:0] closed_events
// apb      | psel, penable, pready=1  | paddr 0 output_mask, 4 closed_threshold, 8 lockout_ms
//
// one beat per cycle while s_tready is high: each pin lane updates in the accepting cycle
// the lane update (compare, subtract, compare) is the single registered step per beat
// a two-entry output register with skid stage keeps input flowing while m_tready is low
// s_tready drops only when both entries hold results
// arst_n clears all counts and lockouts and loads register defaults
module multi_pin_switch_debouncer_unit
	import mpsd_pkg::*;
#(
	parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // elapsed_ms, pin_levels
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [EVENT_W-1:0] m_tdata,   // closed_events
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	cfg_t                 cfg;
	logic                 in_acc;
	logic [TIME_W-1:0]    elapsed;
	logic [LEVEL_W-1:0]   levels;
	logic [PIN_COUNT-1:0] evt;

	assign in_acc  = s_tvalid & s_tready;
	assign elapsed = s_tdata[TIME_W-1:0];
	assign levels  = s_tdata[IN_W-1:TIME_W];

	mpsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one lane per pin; pins past the level word read as low inputs
	for (genvar i = 0; i < PIN_COUNT; i++) begin : g_lane
		logic masked;
		logic level;
		if (i < LEVEL_W) begin : g_vis
			assign masked = cfg.output_mask[i];
			assign level  = levels[i];
		end else begin : g_hid
			assign masked = 1'b0;
			assign level  = 1'b0;
		end

		mpsd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (in_acc),
			.masked  (masked),
			.level   (level),
			.elapsed (elapsed),
			.cfg     (cfg),
			.evt     (evt[i])
		);
	end

	mpsd_merge #(
		.PIN_COUNT (PIN_COUNT)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.in_rdy   (s_tready),
		.evt      (evt),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ rtl/mpsd_regs.sv @@
module mpsd_regs
	import mpsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mask      <= MASK_RST;
			cfg_q.closed_threshold <= THRESHOLD_RST;
			cfg_q.lockout_ms       <= LOCKOUT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_OUTPUT_MASK:      cfg_q.output_mask      <= pwdata[LEVEL_W-1:0];
				REG_CLOSED_THRESHOLD: cfg_q.closed_threshold <= pwdata[COUNT_W-1:0];
				REG_LOCKOUT_MS:       cfg_q.lockout_ms       <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_OUTPUT_MASK:      prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg_q.output_mask};
			REG_CLOSED_THRESHOLD: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_q.closed_threshold};
			REG_LOCKOUT_MS:       prdata = {{(APB_DW-TIME_W){1'b0}}, cfg_q.lockout_ms};
			default:              prdata = '0;
		endcase
	end

endmodule

@@ rtl/mpsd_lane.sv @@
module mpsd_lane
	import mpsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              masked,
	input  logic              level,
	input  logic [TIME_W-1:0] elapsed,
	input  cfg_t              cfg,
	output logic              evt
);

	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  lock_q;
	logic [COUNT_W-1:0] count_a;
	logic [COUNT_W-1:0] count_b;
	logic [TIME_W-1:0]  lock_a;
	logic [COUNT_W-1:0] count_d;
	logic [TIME_W-1:0]  lock_d;

	// event release or lockout countdown
	always_comb begin
		count_a = count_q;
		if (count_q == cfg.closed_threshold) begin
			count_a = '0;
			lock_a  = cfg.lockout_ms;
		end else if (lock_q < elapsed) begin
			lock_a = '0;
		end else begin
			lock_a = lock_q - elapsed;
		end
	end

	// sample the level once the lockout has run out
	always_comb begin
		count_b = count_a;
		if (lock_a == '0) begin
			if (level) begin
				count_b = '0;
			end else if (count_a < cfg.closed_threshold) begin
				count_b = count_a + 1'b1;
			end
		end
	end

	// output pins keep their state
	assign count_d = masked ? count_q : count_b;
	assign lock_d  = masked ? lock_q  : lock_a;
	assign evt     = (count_d == cfg.closed_threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lock_q  <= '0;
		end else if (en) begin
			count_q <= count_d;
			lock_q  <= lock_d;
		end
	end

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(count_q) && $stable(lock_q))
		else $error("lane state changed without a beat");

	a_mask_hold: assert property (@(posedge clk) disable iff (!arst_n)
		en && masked |=> $stable(count_q) && $stable(lock_q))
		else $error("output pin state changed");

	a_lockout_load: assert property (@(posedge clk) disable iff (!arst_n)
		en && !masked && count_q == cfg.closed_threshold |=> lock_q == $past(cfg.lockout_ms))
		else $error("lockout not loaded after event");

endmodule

@@ rtl/mpsd_merge.sv @@
module mpsd_merge
	import mpsd_pkg::*;
#(
	parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_acc,
	output logic                 in_rdy,
	input  logic [PIN_COUNT-1:0] evt,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [EVENT_W-1:0]   m_tdata
);

	logic [EVENT_W-1:0] res;
	logic [EVENT_W-1:0] out_data_q;
	logic [EVENT_W-1:0] skid_data_q;
	logic               out_valid_q;
	logic               skid_valid_q;
	logic               out_free;

	// gather lane flags into the visible result word
	for (genvar i = 0; i < EVENT_W; i++) begin : g_res
		if (i < PIN_COUNT) begin : g_pin
			assign res[i] = evt[i];
		end else begin : g_none
			assign res[i] = 1'b0;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign in_rdy   = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// output register and skid stage, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output register and skid stage, data
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (in_acc) begin
			skid_data_q <= res;
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output is empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && out_valid_q && !m_tready |=> skid_valid_q)
		else $error("beat lost on output stall");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && m_tready |=> out_valid_q && out_data_q == $past(skid_data_q))
		else $error("skid beat not moved to output");

	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted beat gave no result");

endmodule

@@ tb/sv/tb_multi_pin_switch_debouncer_unit.sv @@
module tb_multi_pin_switch_debouncer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mpsd_pkg::*;

	localparam int unsigned PINS        = PIN_COUNT_DEF;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned MAX_PRINTS  = 100;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata  = '0;   // [15:0] elapsed_ms, [31:16] pin_levels
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [EVENT_W-1:0] m_tdata;         // [15:0] closed_events
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [APB_AW-1:0]  paddr    = '0;
	logic [APB_DW-1:0]  pwdata   = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	// debouncer model state and settings
	logic [LEVEL_W-1:0] mask_set;
	logic [COUNT_W-1:0] thresh_set;
	logic [TIME_W-1:0]  hold_off_set;
	logic [COUNT_W-1:0] closures  [PINS];
	logic [TIME_W-1:0]  lock_left [PINS];
	logic [EVENT_W-1:0] events_due[$];

	int mismatches   = 0;
	int steps_sent   = 0;
	int event_beats  = 0;
	int settings_run = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	bit idle_on      = 1'b1;

	multi_pin_switch_debouncer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one debounce step over all pins, returns the closure flags
	function automatic logic [EVENT_W-1:0] debounce_step(input logic [TIME_W-1:0] elapsed,
		input logic [LEVEL_W-1:0] levels);
		logic [EVENT_W-1:0] flags;
		flags = '0;
		for (int p = 0; p < PINS; p++) begin
			if (!mask_set[p]) begin
				// event pins reopen and lock, others run their lockout down
				if (closures[p] == thresh_set) begin
					closures[p]  = '0;
					lock_left[p] = hold_off_set;
				end else if (lock_left[p] < elapsed) begin
					lock_left[p] = '0;
				end else begin
					lock_left[p] = lock_left[p] - elapsed;
				end
				// sample the level once the lockout is over
				if (lock_left[p] == '0) begin
					if (levels[p])
						closures[p] = '0;
					else if (closures[p] < thresh_set)
						closures[p] = closures[p] + 1'b1;
				end
			end
			flags[p] = (closures[p] == thresh_set);
		end
		return flags;
	endfunction

	// gap lengths: mostly short, a few long
	function automatic int stall_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int idle_len();
		if (!idle_on || $urandom_range(0, 99) < 65)
			return 0;
		return stall_len();
	endfunction

	function automatic logic [TIME_W-1:0] pick_elapsed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 75)
			return TIME_W'($urandom_range(1, 20));
		if (r < 90)
			return TIME_W'($urandom_range(21, 1000));
		if (r < 97)
			return TIME_W'($urandom);
		return '1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// one input beat, predicted when accepted
	task automatic send_step(input logic [TIME_W-1:0] elapsed,
		input logic [LEVEL_W-1:0] levels);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {levels, elapsed};
		do @(posedge clk); while (!s_tready);
		events_due.push_back(debounce_step(elapsed, levels));
		steps_sent++;
	endtask

	// stop the stream and wait for every pending result
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [APB_DW-1:0] want,
		input string what);
		logic [APB_DW-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			flag_mismatch(what, got, want);
	endtask

	task automatic readback_settings();
		check_reg(REG_OUTPUT_MASK, APB_DW'(mask_set), "output_mask read");
		check_reg(REG_CLOSED_THRESHOLD, APB_DW'(thresh_set), "closed_threshold read");
		check_reg(REG_LOCKOUT_MS, APB_DW'(hold_off_set), "lockout_ms read");
	endtask

	task automatic load_settings(input logic [LEVEL_W-1:0] mask,
		input logic [COUNT_W-1:0] thresh, input logic [TIME_W-1:0] hold_off);
		drain_results();
		apb_write(REG_OUTPUT_MASK, APB_DW'(mask));
		apb_write(REG_CLOSED_THRESHOLD, APB_DW'(thresh));
		apb_write(REG_LOCKOUT_MS, APB_DW'(hold_off));
		mask_set     = mask;
		thresh_set   = thresh;
		hold_off_set = hold_off;
		readback_settings();
		settings_run++;
	endtask

	// result side: stalls of random length
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 99) < 25) begin
			m_tready   <= 1'b0;
			stall_left <= stall_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_events
		logic [EVENT_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (events_due.size() == 0) begin
				flag_mismatch("closed_events with no step pending", 32'(m_tdata), '0);
			end else begin
				want = events_due.pop_front();
				if (m_tdata !== want)
					flag_mismatch("closed_events", 32'(m_tdata), 32'(want));
			end
			if (m_tdata != '0)
				event_beats++;
		end
	end

	// watchdog on cycles without any beat or register access
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// defaults after reset, then a few steps with them
	task automatic test_reset_defaults();
		readback_settings();
		send_step(16'd0, 16'h0000);
		send_step(16'hFFFF, 16'h0000);
		send_step(16'd1, 16'hFFFF);
	endtask

	// lockout zero: a pin samples again in the step of its event
	task automatic test_lockout_zero();
		load_settings(16'h0000, 8'd1, 16'd0);
		send_step(16'd5, 16'h0000);
		send_step(16'd0, 16'h0000);
		send_step(16'd3, 16'hFFFF);
		send_step(16'd7, 16'h5555);
	endtask

	// longest lockout, released by the largest elapsed time
	task automatic test_lockout_extremes();
		load_settings(16'h0000, 8'd2, 16'hFFFF);
		send_step(16'd1, 16'h0000);
		send_step(16'd1, 16'h0000);
		send_step(16'd1, 16'h0000);
		send_step(16'hFFFF, 16'hAAAA);
		send_step(16'd0, 16'h0000);
	endtask

	// threshold dropped below a running count holds until a high level
	task automatic test_threshold_lowered();
		load_settings(16'h0000, 8'd5, 16'd0);
		repeat (3) send_step(16'd2, 16'h0000);
		load_settings(16'h0000, 8'd2, 16'd0);
		send_step(16'd2, 16'h0000);
		send_step(16'd2, 16'h0000);
		send_step(16'd2, 16'h00FF);
	endtask

	// masked pins freeze but keep reporting their flag
	task automatic test_output_mask();
		load_settings(16'h0000, 8'd3, 16'd0);
		repeat (3) send_step(16'd1, 16'h0000);
		load_settings(16'hF0F0, 8'd3, 16'd0);
		send_step(16'd1, 16'hFFFF);
		send_step(16'd1, 16'hFFFF);
	endtask

	// threshold zero: every pin flags and reloads on every step
	task automatic test_threshold_zero();
		load_settings(16'h0000, 8'd0, 16'd10);
		send_step(16'd4, 16'h1234);
		send_step(16'd20, 16'hFFFF);
	endtask

	// settled switch patterns with bounce, glitches and held pins
	task automatic test_random_sweeps();
		logic [LEVEL_W-1:0] mask, pattern, held_low, levels;
		logic [COUNT_W-1:0] thresh;
		logic [TIME_W-1:0]  hold_off;
		int steps, r;
		pattern = LEVEL_W'($urandom);
		for (int ph = 0; ph < 9; ph++) begin
			held_low = LEVEL_W'($urandom & $urandom);
			case (ph)
				0: begin mask = '0; thresh = 8'd20; hold_off = 16'd200; steps = 150; end
				1: begin mask = '0; thresh = 8'd1; hold_off = 16'd0; steps = 150; end
				2: begin
					mask = LEVEL_W'($urandom); thresh = COUNT_W'($urandom_range(2, 8));
					hold_off = TIME_W'($urandom_range(0, 60)); steps = 200;
				end
				3: begin mask = '1; thresh = 8'd4; hold_off = 16'd5; steps = 100; end
				4: begin mask = '0; thresh = 8'd255; hold_off = '1; steps = 150; end
				5: begin mask = '0; thresh = 8'd255; hold_off = 16'd10; steps = 300; end
				default: begin
					mask = LEVEL_W'($urandom & $urandom);
					thresh = COUNT_W'($urandom_range(1, 12));
					hold_off = TIME_W'($urandom_range(0, 300)); steps = 180;
				end
			endcase
			load_settings(mask, thresh, hold_off);
			for (int k = 0; k < steps; k++) begin
				if (k % 64 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				pattern ^= LEVEL_W'($urandom & $urandom & $urandom & $urandom);
				levels = pattern & ~held_low;
				r = $urandom_range(0, 99);
				if (r < 8)
					levels ^= LEVEL_W'($urandom & $urandom & $urandom);
				else if (r < 12)
					levels = LEVEL_W'($urandom);
				send_step(pick_elapsed(), levels);
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		mask_set     = MASK_RST;
		thresh_set   = THRESHOLD_RST;
		hold_off_set = LOCKOUT_RST;
		for (int p = 0; p < PINS; p++) begin
			closures[p]  = '0;
			lock_left[p] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_lockout_zero();
		test_lockout_extremes();
		test_threshold_lowered();
		test_output_mask();
		test_threshold_zero();
		test_random_sweeps();

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d debounce steps under %0d register settings", steps_sent,
			settings_run);
		$display("%0d result beats carried closure flags, %0d mismatches", event_beats,
			mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
